// ===== rtl/core/bc3_block_texel_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// BC3 texel decoder assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BC3_BLOCK_TEXEL_DECODER_MACROS_SVH
`define BC3_BLOCK_TEXEL_DECODER_MACROS_SVH

// same-cycle implication
`define BC3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BC3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bc3_pkg.sv =====
// ----------------------------------------------------------------------------
// bc3_pkg
// Word types, mode codes and arithmetic helpers for the BC3 texel decoder.
// ----------------------------------------------------------------------------
package bc3_pkg;

	localparam int NUM_TEXELS = 16;

	typedef struct packed {
		logic [7:0]  alpha_end_a;
		logic [7:0]  alpha_end_b;
		logic [47:0] alpha_codes;
		logic [15:0] color_end_a;
		logic [15:0] color_end_b;
		logic [31:0] color_codes;
	} block_t;

	typedef struct packed {
		logic [3:0] texel_index;
		logic [7:0] alpha_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_texel;
	} texel_t;

	// how stage 2 finishes the alpha value
	typedef enum logic [1:0] {
		AMODE_DIRECT = 2'd0,
		AMODE_DIV5   = 2'd1,
		AMODE_DIV7   = 2'd2
	} amode_t;

	localparam logic [7:0] EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd40,  8'd48,  8'd56,
		8'd65,  8'd73,  8'd81,  8'd89,  8'd100, 8'd108, 8'd118, 8'd125,
		8'd135, 8'd143, 8'd152, 8'd162, 8'd170, 8'd178, 8'd186, 8'd194,
		8'd202, 8'd210, 8'd217, 8'd225, 8'd232, 8'd240, 8'd246, 8'd255
	};

	function automatic logic [7:0] expand5(input logic [4:0] v);
		return EXPAND5[v];
	endfunction

	// x <= 1785: floor(x * 2341 / 2^14) == floor(x / 7)
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd2341;
		return p[21:14];
	endfunction

	// x <= 1275: floor(x * 3277 / 2^14) == floor(x / 5)
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd3277;
		return p[21:14];
	endfunction

	// x <= 93: floor(x * 171 / 2^9) == floor(x / 3)
	function automatic logic [4:0] div3(input logic [6:0] x);
		logic [14:0] p;
		p = {8'd0, x} * 15'd171;
		return p[13:9];
	endfunction

endpackage

// ===== rtl/core/bc3_block_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// bc3_block_texel_decoder
// Decodes one BC3 compressed 4x4 block into 16 ARGB texels.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive block and raise start; the word is taken at a clock edge
//   with start high and busy low.
//   Output: valid strobes for one cycle per texel with texel carrying the
//   word. Texels come in row-major order, one per cycle, the last one with
//   last_texel set. The receiver cannot stall; results must be taken.
//   Config: cfg_we with cfg_data writes use_alpha (reset value 1); write
//   only while no block is in flight.
//   Path: a taken block is held in the block register; each texel then
//   passes the stage 1 register and the stage 2 output register.
//   Throughput: set by the single texel lane that decodes one texel a
//   cycle. busy drops during the cycle the lane works on texel 15, so the
//   next block is taken then and its texels follow without a gap.
//   Reset: arst_n clears the pipeline; use_alpha returns to 1.
// ----------------------------------------------------------------------------
`include "bc3_block_texel_decoder_macros.svh"

module bc3_block_texel_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bc3_pkg::block_t block,
	input  logic            cfg_we,
	input  logic            cfg_data,
	output logic            valid,
	output bc3_pkg::texel_t texel
);

	// block register and texel counter
	bc3_pkg::block_t block_q;
	logic [3:0]      idx_q;
	logic            active_q;
	logic            use_alpha_q;
	logic            accept;

	// stage 1: weighted sums
	logic             valid_s1;
	logic [3:0]       idx_s1;
	logic [10:0]      asum_s1;
	bc3_pkg::amode_t  amode_s1;
	logic [6:0]       rsum_s1, gsum_s1, bsum_s1;
	logic             cdiv_s1;

	// stage 2: output register
	logic             valid_s2;
	bc3_pkg::texel_t  texel_s2;

	assign busy   = active_q && (idx_q != 4'd15);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_alpha_q <= 1'b1;
		end else if (cfg_we) begin
			use_alpha_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 4'd0;
		end else if (accept) begin
			active_q <= 1'b1;
			idx_q    <= 4'd0;
		end else if (active_q) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q == 4'd15) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_q <= block;
		end
	end

	// ---- stage 1 logic ----
	logic [15:0][2:0] acodes;
	logic [15:0][1:0] ccodes;
	logic [2:0]       ac;
	logic [1:0]       cc;
	logic [2:0]       wa, wb;
	logic [10:0]      asum;
	bc3_pkg::amode_t  amode;

	assign acodes = block_q.alpha_codes;
	assign ccodes = block_q.color_codes;
	assign ac     = acodes[idx_q];
	assign cc     = ccodes[idx_q];

	function automatic logic [6:0] mix_sum(input logic [4:0] a, input logic [4:0] b,
	                                       input logic [1:0] code);
		logic [6:0] r;
		case (code)
			2'd0:    r = {2'd0, a};
			2'd1:    r = {2'd0, b};
			2'd2:    r = {1'b0, a, 1'b0} + {2'd0, b};
			2'd3:    r = {2'd0, a} + {1'b0, b, 1'b0};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		wa    = 3'd0;
		wb    = 3'd0;
		asum  = 11'd0;
		amode = bc3_pkg::AMODE_DIRECT;
		if (!use_alpha_q) begin
			asum = 11'd255;
		end else if (ac == 3'd0) begin
			asum = {3'd0, block_q.alpha_end_a};
		end else if (ac == 3'd1) begin
			asum = {3'd0, block_q.alpha_end_b};
		end else if (block_q.alpha_end_a <= block_q.alpha_end_b) begin
			// six-step mode
			if (ac == 3'd6) begin
				asum = 11'd0;
			end else if (ac == 3'd7) begin
				asum = 11'd255;
			end else begin
				wa    = 3'd6 - ac;
				wb    = ac - 3'd1;
				asum  = 11'(wa) * 11'(block_q.alpha_end_a)
				      + 11'(wb) * 11'(block_q.alpha_end_b);
				amode = bc3_pkg::AMODE_DIV5;
			end
		end else begin
			wa    = 3'd0 - ac; // 8 - code, modulo 8
			wb    = ac - 3'd1;
			asum  = 11'(wa) * 11'(block_q.alpha_end_a)
			      + 11'(wb) * 11'(block_q.alpha_end_b);
			amode = bc3_pkg::AMODE_DIV7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			idx_s1   <= idx_q;
			asum_s1  <= asum;
			amode_s1 <= amode;
			rsum_s1  <= mix_sum(block_q.color_end_a[15:11], block_q.color_end_b[15:11], cc);
			gsum_s1  <= mix_sum(block_q.color_end_a[10:6], block_q.color_end_b[10:6], cc);
			bsum_s1  <= mix_sum(block_q.color_end_a[4:0], block_q.color_end_b[4:0], cc);
			cdiv_s1  <= cc[1];
		end
	end

	// ---- stage 2 logic ----
	logic [7:0] alpha_val;
	logic [4:0] r5, g5, b5;

	always_comb begin
		case (amode_s1)
			bc3_pkg::AMODE_DIRECT: alpha_val = asum_s1[7:0];
			bc3_pkg::AMODE_DIV5:   alpha_val = bc3_pkg::div5(asum_s1);
			bc3_pkg::AMODE_DIV7:   alpha_val = bc3_pkg::div7(asum_s1);
			default:               alpha_val = 8'd0;
		endcase
	end

	assign r5 = cdiv_s1 ? bc3_pkg::div3(rsum_s1) : rsum_s1[4:0];
	assign g5 = cdiv_s1 ? bc3_pkg::div3(gsum_s1) : gsum_s1[4:0];
	assign b5 = cdiv_s1 ? bc3_pkg::div3(bsum_s1) : bsum_s1[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			texel_s2.texel_index <= idx_s1;
			texel_s2.alpha_out   <= alpha_val;
			texel_s2.red_out     <= bc3_pkg::expand5(r5);
			texel_s2.green_out   <= bc3_pkg::expand5(g5);
			texel_s2.blue_out    <= bc3_pkg::expand5(b5);
			texel_s2.last_texel  <= (idx_s1 == 4'd15);
		end
	end

	assign valid = valid_s2;
	assign texel = texel_s2;

	// ---- assertions ----
	`BC3_ASSERT_NEXT(a_accept_starts, accept, active_q && (idx_q == 4'd0), "block not started")
	`BC3_ASSERT_NOW(a_busy_active, busy, active_q, "busy without active block")
	`BC3_ASSERT_NEXT(a_texel_seq, valid && (texel.texel_index != 4'd15), valid && (texel.texel_index == $past(texel.texel_index) + 4'd1), "texel sequence broken")
	`BC3_ASSERT_NOW(a_last_flag, valid, texel.last_texel == (texel.texel_index == 4'd15), "last flag mismatch")

endmodule
